FILE: rtl/avric_pkg.sv
// shared types and constants of the interrupt controller
`default_nettype none
package avric_pkg;

  // request codes
  localparam logic [2:0] REQ_RAISE = 3'd0;
  localparam logic [2:0] REQ_CLEAR = 3'd1;
  localparam logic [2:0] REQ_TICK  = 3'd2;
  localparam logic [2:0] REQ_RETI  = 3'd3;
  localparam logic [2:0] REQ_ENA   = 3'd4;
  localparam logic [2:0] REQ_PRIO  = 3'd5;
  localparam logic [2:0] REQ_SEI   = 3'd6;

  // configuration register indexes
  localparam logic [2:0] CFG_MODERN = 3'd0;
  localparam logic [2:0] CFG_L1     = 3'd1;
  localparam logic [2:0] CFG_RR     = 3'd2;
  localparam logic [2:0] CFG_NMI    = 3'd3;
  localparam logic [2:0] CFG_HIGH   = 3'd4;
  localparam logic [2:0] CFG_WPV    = 3'd5;

  // execution level flags
  localparam int FLAG_L0  = 0;
  localparam int FLAG_L1  = 1;
  localparam int FLAG_NMI = 2;

  // arm state codes (two's complement of -2..1)
  localparam logic [2:0] ARM_IDLE  = 3'd0;
  localparam logic [2:0] ARM_ON    = 3'd1;
  localparam logic [2:0] ARM_DLY1  = 3'b111;
  localparam logic [2:0] ARM_DLY2  = 3'b110;

  // controller commands to the datapath
  typedef struct packed {
    logic capture;   // latch request
    logic scan_clr;  // start winner scan
    logic scan_step; // one rank setup step or one vector of the scan
    logic commit;    // apply the request
  } avric_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic scan_done;
  } avric_sts_t;

endpackage
`default_nettype wire

FILE: rtl/avric_ctrl.sv
// controller state machine: capture, scan, commit, deliver
`default_nettype none
module avric_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_stall,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      avric_pkg::avric_cmd_t cmd,
  input  wire avric_pkg::avric_sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_COMMIT = 4'b0100,
    ST_OUT    = 4'b1000
  } state_t;

  state_t state, state_next;

  // a new transfer may enter only in idle, never while the last result waits
  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture  = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule
`default_nettype wire

FILE: rtl/avric_dp.sv
// datapath: vector bits, serial winner scan, running stack and result register
`default_nettype none
module avric_dp #(
  parameter int NUM_VECTORS = 32,
  parameter int NEST_DEPTH  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire avric_pkg::avric_cmd_t cmd,
  output      avric_pkg::avric_sts_t sts,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [4:0]  cfg_data,
  input  wire logic [2:0]  req_type,
  input  wire logic [4:0]  vector_num,
  input  wire logic        enable_value,
  input  wire logic [4:0]  priority_value,
  input  wire logic        i_bit,
  input  wire logic        protect_window,
  input  wire logic [21:0] current_pc,
  output      logic        raise_accepted,
  output      logic        take_interrupt,
  output      logic [4:0]  taken_vector,
  output      logic [21:0] jump_address,
  output      logic [21:0] return_address,
  output      logic        clear_i_bit,
  output      logic        wake_core,
  output      logic        any_pending,
  output      logic [4:0]  running_top,
  output      logic [2:0]  exec_levels,
  output      logic        nest_overflow
);

  localparam int NV  = (NUM_VECTORS < 32) ? NUM_VECTORS : 32;
  localparam int SW  = (NV > 1) ? $clog2(NV) : 1;
  localparam int DW  = $clog2(NEST_DEPTH + 1);
  localparam int PW  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int RSTEPS = 9;

  // configuration registers
  logic       modern_mode, round_robin;
  logic [4:0] level1_vector, nmi_vector, highest_vector;
  logic [2:0] words_per_vector;

  always_ff @(posedge clk) begin
    if (rst) begin
      modern_mode <= 1'b0; level1_vector <= '0; round_robin <= 1'b0;
      nmi_vector <= '0; highest_vector <= '0; words_per_vector <= 3'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        avric_pkg::CFG_MODERN: modern_mode      <= cfg_data[0];
        avric_pkg::CFG_L1:     level1_vector    <= cfg_data;
        avric_pkg::CFG_RR:     round_robin      <= cfg_data[0];
        avric_pkg::CFG_NMI:    nmi_vector       <= cfg_data;
        avric_pkg::CFG_HIGH:   highest_vector   <= cfg_data;
        avric_pkg::CFG_WPV:    words_per_vector <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // captured request
  logic [2:0]  rq;
  logic [4:0]  rv;
  logic        ren, ribit, rccp;
  logic [4:0]  rpri;
  logic [21:0] rpc;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rq <= req_type; rv <= vector_num; ren <= enable_value;
      rpri <= priority_value; ribit <= i_bit; rccp <= protect_window;
      rpc <= current_pc;
    end
  end

  // controller state
  logic [NV-1:0] pend, enab;
  logic [2:0]    arm;
  logic [DW-1:0] depth;
  logic [2:0]    lflags;
  logic [4:0]    base;
  logic [4:0]    stk [NEST_DEPTH];

  // serial scan: rank setup, then one candidate per cycle, vector 1 upward
  logic [SW:0]  idx;
  logic         bvalid;
  logic [4:0]   bvec;
  logic [1:0]   blev;
  logic [4:0]   brank;
  logic         cvalid;
  logic [1:0]   clev;
  logic [4:0]   crank;
  logic [4:0]   cvec;
  logic [5:0]   m;
  logic [6:0]   twom;
  logic         vok;
  // level-0 rank of the current candidate, kept as a running remainder
  logic [3:0]   dcnt;
  logic [8:0]   wreg;
  logic [5:0]   rem;
  logic [6:0]   rtry;
  logic [3:0]   wrapc;
  logic         negx;
  logic [8:0]   wdiv;
  logic         zcross;
  logic [5:0]   rinc;

  assign cvec = 5'(idx);
  assign m    = (highest_vector != 5'd0) ? ({1'b0, highest_vector} + 6'd1) : 6'd1;
  assign twom = {m, 1'b0};
  assign vok  = ({1'b0, rv} < 6'(NV));
  assign sts.scan_done = (dcnt == 4'd0) && (idx >= (SW+1)'(NV - 1));

  // 2^32 mod m, needed only when the rank of vector 1 wraps below zero (m < 16)
  always_comb begin
    case (m)
      6'd3, 6'd5, 6'd15:                      wrapc = 4'd1;
      6'd6, 6'd7, 6'd9, 6'd11, 6'd12, 6'd14:  wrapc = 4'd4;
      6'd10:                                  wrapc = 4'd6;
      6'd13:                                  wrapc = 4'd9;
      default:                                wrapc = 4'd0;
    endcase
  end

  // starting rank dividend: 2m - base, taken modulo 2^32 when it is negative
  assign negx = (7'(base) > twom);
  assign wdiv = negx ? (9'(wrapc) + {m[3:0], 5'd0} + 9'(twom) - 9'(base))
                     : (9'(twom) - 9'(base));
  assign rtry = {rem, wreg[8]};
  // rank wraps to zero where the 32-bit difference crosses zero
  assign zcross = ((7'(cvec) + twom) == 7'(base));
  assign rinc = (rem + 6'd1 == m) ? 6'd0 : rem + 6'd1;

  always_comb begin
    clev = 2'd0;
    if (nmi_vector != 5'd0 && cvec == nmi_vector) clev = 2'd2;
    else if (level1_vector != 5'd0 && cvec == level1_vector) clev = 2'd1;
    crank = (clev == 2'd0) ? rem[4:0] : cvec;
    cvalid = 1'b0;
    if (idx < (SW+1)'(NV) && pend[idx[SW-1:0]]) begin
      if (!modern_mode) cvalid = 1'b1;
      else if (enab[idx[SW-1:0]]) begin
        case (clev)
          2'd2: cvalid = !lflags[avric_pkg::FLAG_NMI];
          2'd1: cvalid = ribit && !lflags[avric_pkg::FLAG_NMI] &&
                         !lflags[avric_pkg::FLAG_L1];
          default: cvalid = ribit && (lflags == 3'd0);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      idx <= (SW+1)'(1); bvalid <= 1'b0;
      bvec <= '0; blev <= '0; brank <= '0;
      dcnt <= 4'(RSTEPS); wreg <= wdiv; rem <= '0;
    end else if (cmd.scan_step) begin
      if (dcnt != 4'd0) begin
        // one restoring step of the starting rank
        dcnt <= dcnt - 4'd1;
        wreg <= {wreg[7:0], 1'b0};
        if (rtry >= 7'(m)) rem <= 6'(rtry - 7'(m));
        else rem <= rtry[5:0];
      end else begin
        if (!sts.scan_done) idx <= idx + (SW+1)'(1);
        rem <= zcross ? 6'd0 : rinc;
        if (cvalid) begin
          if (!modern_mode) begin
            if (!bvalid) begin bvalid <= 1'b1; bvec <= cvec; end
          end else if (!bvalid || clev > blev || (clev == blev && crank < brank)) begin
            bvalid <= 1'b1; bvec <= cvec; blev <= clev; brank <= crank;
          end
        end
      end
    end
  end

  // commit of the captured request
  logic [NV-1:0] pend_next, enab_next;
  logic [2:0]    arm_next, lflags_next;
  logic [DW-1:0] depth_next;
  logic [4:0]    base_next;
  logic          acc, take, cli, wake, ovf, push;
  logic [SW-1:0] rvi, bvi;

  assign rvi = rv[SW-1:0];
  assign bvi = bvec[SW-1:0];

  always_comb begin
    pend_next = pend; enab_next = enab; arm_next = arm; lflags_next = lflags;
    depth_next = depth; base_next = base;
    acc = 1'b0; take = 1'b0; cli = 1'b0; wake = 1'b0; ovf = 1'b0; push = 1'b0;
    case (rq)
      avric_pkg::REQ_RAISE: begin
        if (rv != 5'd0 && vok && !pend[rvi]) begin
          acc = 1'b1;
          if (enab[rvi]) begin
            pend_next[rvi] = 1'b1; wake = 1'b1;
            if (arm == avric_pkg::ARM_IDLE && (modern_mode || ribit))
              arm_next = avric_pkg::ARM_ON;
          end
        end
      end
      avric_pkg::REQ_CLEAR: if (vok) pend_next[rvi] = 1'b0;
      avric_pkg::REQ_TICK: begin
        if ((!modern_mode && ribit && arm != avric_pkg::ARM_IDLE) ||
            (modern_mode && !rccp)) begin
          if (arm[2]) begin
            arm_next = arm + 3'd1;
            if (arm == avric_pkg::ARM_DLY1)
              arm_next = (|pend) ? avric_pkg::ARM_ON : avric_pkg::ARM_IDLE;
          end else if (arm != avric_pkg::ARM_IDLE) begin
            if (!bvalid) arm_next = avric_pkg::ARM_IDLE;
            else if (!modern_mode) begin
              pend_next[bvi] = 1'b0;
              if (!enab[bvi]) begin
                arm_next = (|pend_next) ? avric_pkg::ARM_ON : avric_pkg::ARM_IDLE;
              end else begin
                take = 1'b1; cli = 1'b1; push = 1'b1;
              end
            end else begin
              take = 1'b1; push = 1'b1;
              pend_next[bvi] = 1'b0;
              if (blev == 2'd2) lflags_next[avric_pkg::FLAG_NMI] = 1'b1;
              else if (blev == 2'd1) lflags_next[avric_pkg::FLAG_L1] = 1'b1;
              else begin
                lflags_next[avric_pkg::FLAG_L0] = 1'b1;
                if (round_robin) base_next = bvec;
              end
              arm_next = (|pend_next) ? avric_pkg::ARM_ON : avric_pkg::ARM_IDLE;
            end
          end
        end
        if (push) begin
          if (depth >= DW'(NEST_DEPTH)) ovf = 1'b1;
          else depth_next = depth + DW'(1);
        end
      end
      avric_pkg::REQ_RETI: begin
        if (depth != '0) depth_next = depth - DW'(1);
        if (modern_mode) begin
          if (lflags[avric_pkg::FLAG_NMI]) lflags_next[avric_pkg::FLAG_NMI] = 1'b0;
          else if (lflags[avric_pkg::FLAG_L1]) lflags_next[avric_pkg::FLAG_L1] = 1'b0;
          else lflags_next[avric_pkg::FLAG_L0] = 1'b0;
          if (arm == avric_pkg::ARM_IDLE && (|pend)) arm_next = avric_pkg::ARM_ON;
        end
      end
      avric_pkg::REQ_ENA:  if (vok) enab_next[rvi] = ren;
      avric_pkg::REQ_PRIO: base_next = rpri;
      avric_pkg::REQ_SEI:  if (!ribit) arm_next = avric_pkg::ARM_DLY2;
      default: ;
    endcase
    pend_next[0] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0; enab <= '0; arm <= avric_pkg::ARM_IDLE; depth <= '0;
      lflags <= '0; base <= '0;
    end else if (cmd.commit) begin
      pend <= pend_next; enab <= enab_next; arm <= arm_next; depth <= depth_next;
      lflags <= lflags_next; base <= base_next;
    end
  end

  // running stack write
  always_ff @(posedge clk) begin
    if (cmd.commit && push && !ovf) stk[depth[PW-1:0]] <= bvec;
  end

  // result register
  logic [4:0] top_next;
  always_comb begin
    top_next = '0;
    if (depth_next != '0) top_next = stk[PW'(depth_next - DW'(1))];
    if (push && !ovf && depth_next == depth + DW'(1)) top_next = bvec;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      raise_accepted <= acc;
      take_interrupt <= take;
      taken_vector   <= take ? bvec : 5'd0;
      jump_address   <= take ? ({17'd0, bvec} * {19'd0, words_per_vector}) : 22'd0;
      return_address <= take ? rpc : 22'd0;
      clear_i_bit    <= cli;
      wake_core      <= wake;
      any_pending    <= |pend_next;
      running_top    <= top_next;
      exec_levels    <= lflags_next;
      nest_overflow  <= ovf;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/avr_interrupt_controller_top.sv
// top level of the interrupt controller
// Each request first sets up the level-0 rank of vector 1, then takes one
// vector per cycle from 1 to NUM_VECTORS-1 in the serial priority scan, then
// a commit loads the result register. One request is held at a time; the
// next is taken in the cycle after the result transfer. Configuration writes
// go straight to the registers and must be made by the user while the block
// is idle; the block itself does not enforce it.
`default_nettype none
module avr_interrupt_controller_top #(
  parameter int NUM_VECTORS = 32,
  parameter int NEST_DEPTH  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [4:0]  vector_num,
  input  wire logic        enable_value,
  input  wire logic [4:0]  priority_value,
  input  wire logic        i_bit,
  input  wire logic        protect_window,
  input  wire logic [21:0] current_pc,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        raise_accepted,
  output      logic        take_interrupt,
  output      logic [4:0]  taken_vector,
  output      logic [21:0] jump_address,
  output      logic [21:0] return_address,
  output      logic        clear_i_bit,
  output      logic        wake_core,
  output      logic        any_pending,
  output      logic [4:0]  running_top,
  output      logic [2:0]  exec_levels,
  output      logic        nest_overflow
);

  avric_pkg::avric_cmd_t cmd;
  avric_pkg::avric_sts_t sts;

  avric_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  avric_dp #(.NUM_VECTORS(NUM_VECTORS), .NEST_DEPTH(NEST_DEPTH)) u_dp (
    .clk, .rst, .cmd, .sts, .cfg_we, .cfg_index, .cfg_data,
    .req_type, .vector_num, .enable_value, .priority_value, .i_bit,
    .protect_window, .current_pc,
    .raise_accepted, .take_interrupt, .taken_vector, .jump_address,
    .return_address, .clear_i_bit, .wake_core, .any_pending, .running_top,
    .exec_levels, .nest_overflow
  );

  // no new transfer while a result is shown
  a_excl: assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input taken while result pending");
  // an entry always carries a vector
  a_take: assert property (@(posedge clk) disable iff (rst)
    (out_valid && take_interrupt) |-> (taken_vector != 5'd0))
    else $error("entry without vector");
  // classic I-bit clear only with an entry
  a_cli: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clear_i_bit) |-> take_interrupt)
    else $error("clear_i_bit without entry");

endmodule
`default_nettype wire
